FILE: rtl/sre_pkg.sv
// Shared constants, types and the digit lookup of the signed radix digit emitter.
`timescale 1ns / 1ps

package sre_pkg;

   // Defaults for the top-level parameters.
   localparam int MAX_BASE_DEFAULT   = 16;
   localparam int VALUE_BITS_DEFAULT = 32;

   // Fixed field widths.
   localparam int CHAR_BITS      = 8;
   localparam int BASE_BITS      = 5;
   localparam int TABLE_BITS     = 64;
   localparam int ALPHA_DEPTH    = 16;
   localparam int ALPHA_IDX_BITS = 4;
   localparam int CSR_IDX_BITS   = 2;

   // Register indexes of the configuration port.
   localparam logic [CSR_IDX_BITS-1:0] REG_BASE_SIZE = 2'd0;
   localparam logic [CSR_IDX_BITS-1:0] REG_DIGIT_LO  = 2'd1;
   localparam logic [CSR_IDX_BITS-1:0] REG_DIGIT_HI  = 2'd2;

   // Reset contents: radix 16, alphabet "0123456789abcdef".
   localparam logic [BASE_BITS-1:0]  BASE_SIZE_RESET = 5'd16;
   localparam logic [TABLE_BITS-1:0] DIGIT_LO_RESET  = 64'h3736_3534_3332_3130;
   localparam logic [TABLE_BITS-1:0] DIGIT_HI_RESET  = 64'h6665_6463_6261_3938;

   // Smallest usable radix.
   localparam logic [BASE_BITS-1:0] MIN_BASE = 5'd2;

   // Characters with a meaning of their own.
   localparam logic [CHAR_BITS-1:0] CH_PLUS  = 8'h2B;
   localparam logic [CHAR_BITS-1:0] CH_MINUS = 8'h2D;
   localparam logic [CHAR_BITS-1:0] CH_NUL   = 8'h00;

   // Sequencer states.
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CHECK,
      ST_DIV_LOAD,
      ST_DIV_WAIT,
      ST_SIGN,
      ST_DIGITS
   } sre_state_type;

   // Commands to the digit stack.
   typedef struct packed {
      logic clear;
      logic push;
      logic pop;
   } stack_ctrl_type;

   // Character of digit k: bytes 0 to 7 of the low table, then the high table.
   function automatic logic [CHAR_BITS-1:0] digit_char(
      input logic [TABLE_BITS-1:0]     lo,
      input logic [TABLE_BITS-1:0]     hi,
      input logic [ALPHA_IDX_BITS-1:0] k
   );
      logic [TABLE_BITS-1:0] word;
      word = k[ALPHA_IDX_BITS-1] ? hi : lo;
      return word[{k[ALPHA_IDX_BITS-2:0], 3'b000} +: CHAR_BITS];
   endfunction

endpackage

FILE: rtl/sre_if.sv
// Valid/ready channel interfaces for the request and response sides.
`timescale 1ns / 1ps

interface sre_req_if import sre_pkg::*; #(
   parameter int VALUE_BITS = VALUE_BITS_DEFAULT
);
   logic                         valid;
   logic                         ready;
   logic signed [VALUE_BITS-1:0] value;

   modport source (output valid, output value, input ready);
   modport sink   (input valid, input value, output ready);
endinterface

interface sre_rsp_if import sre_pkg::*;;
   logic                 valid;
   logic                 ready;
   logic [CHAR_BITS-1:0] out_char;
   logic                 last;

   modport source (output valid, output out_char, output last, input ready);
   modport sink   (input valid, input out_char, input last, output ready);
endinterface

FILE: rtl/signed_radix_digit_emitter.sv
// Top level: configuration registers, sequencer and datapath of the radix digit emitter.
//
//   Channel   Direction  Handshake       Carries
//   req_chan  in         valid / ready   value, signed, VALUE_BITS bits
//   rsp_chan  out        valid / ready   out_char (8 bits), last
//   csr_*     in         csr_wr_en only  csr_index, csr_wr_data (64 bits)
//
// One number at a time. After the transfer the alphabet is scanned one entry a cycle,
// then each digit takes one division on the shared bit-serial divider, followed by one
// character per cycle while the sink is ready.
// A bad radix or alphabet entry ends the item during the scan with no characters.
// Reset is synchronous and restores radix 16 with the alphabet "0123456789abcdef".
// A stalled sink holds the current character; no request is taken until the last one.
`timescale 1ns / 1ps

module signed_radix_digit_emitter import sre_pkg::*; #(
   parameter int MAX_BASE   = MAX_BASE_DEFAULT,
   parameter int VALUE_BITS = VALUE_BITS_DEFAULT
) (
   input  logic                    clock,
   input  logic                    reset,
   sre_req_if.sink                 req_chan,
   sre_rsp_if.source               rsp_chan,
   input  logic                    csr_wr_en,
   input  logic [CSR_IDX_BITS-1:0] csr_index,
   input  logic [TABLE_BITS-1:0]   csr_wr_data
);

   localparam int DIGIT_BITS = $clog2(MAX_BASE);
   localparam int CNT_BITS   = $clog2(VALUE_BITS + 1);
   localparam logic [BASE_BITS-1:0] TOP_BASE  = BASE_BITS'(MAX_BASE);
   localparam logic [CNT_BITS-1:0]  MAX_DIGITS = CNT_BITS'(VALUE_BITS);
   localparam logic [CNT_BITS-1:0]  ONE_LEFT   = CNT_BITS'(1);

   // Configuration registers.
   logic [BASE_BITS-1:0]  base_size_ff;
   logic [TABLE_BITS-1:0] digit_lo_ff;
   logic [TABLE_BITS-1:0] digit_hi_ff;

   // Sequencer and working registers.
   sre_state_type               state_ff, state_in;
   logic                        neg_ff, neg_in;
   logic [VALUE_BITS-1:0]       mag_ff, mag_in;
   logic [ALPHA_IDX_BITS-1:0]   scan_idx_ff, scan_idx_in;

   // Datapath signals.
   logic [VALUE_BITS-1:0] req_bits;
   logic [VALUE_BITS-1:0] req_mag;
   logic                  base_bad;
   logic                  char_bad;
   logic                  scan_end;
   logic                  div_start;
   logic                  div_done;
   logic [VALUE_BITS-1:0] div_quo;
   logic [DIGIT_BITS-1:0] div_rem;
   stack_ctrl_type        stack_ctrl;
   logic [DIGIT_BITS-1:0] stack_top;
   logic [CNT_BITS-1:0]   stack_count;
   logic [CNT_BITS-1:0]   count_after;
   logic                  more_digits;
   logic                  req_xfer;
   logic                  rsp_xfer;

   // Configuration writes; indexes beyond the list are ignored.
   always_ff @(posedge clock) begin
      if (reset) begin
         base_size_ff <= BASE_SIZE_RESET;
         digit_lo_ff  <= DIGIT_LO_RESET;
         digit_hi_ff  <= DIGIT_HI_RESET;
      end else if (csr_wr_en) begin
         case (csr_index)
            REG_BASE_SIZE: base_size_ff <= csr_wr_data[BASE_BITS-1:0];
            REG_DIGIT_LO:  digit_lo_ff  <= csr_wr_data;
            REG_DIGIT_HI:  digit_hi_ff  <= csr_wr_data;
            default:       ;
         endcase
      end
   end

   // Magnitude of the request; the most negative value wraps to its own unsigned form.
   assign req_bits = req_chan.value;
   assign req_mag  = req_bits[VALUE_BITS-1] ? (~req_bits + 1'b1) : req_bits;

   // Alphabet checks: radix range at once, entries one per cycle.
   assign base_bad = (base_size_ff < MIN_BASE) || (base_size_ff > TOP_BASE);
   assign scan_end = BASE_BITS'(scan_idx_ff) == (base_size_ff - 1'b1);

   sre_alpha_scan u_alpha_scan (
      .digit_lo (digit_lo_ff),
      .digit_hi (digit_hi_ff),
      .idx      (scan_idx_ff),
      .bad      (char_bad)
   );

   sre_divider #(
      .VALUE_BITS (VALUE_BITS),
      .MAX_BASE   (MAX_BASE)
   ) u_divider (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (mag_ff),
      .divisor   (base_size_ff),
      .done      (div_done),
      .quotient  (div_quo),
      .remainder (div_rem)
   );

   sre_digit_stack #(
      .DEPTH     (VALUE_BITS),
      .DATA_BITS (DIGIT_BITS)
   ) u_digit_stack (
      .clock     (clock),
      .reset     (reset),
      .ctrl      (stack_ctrl),
      .push_data (div_rem),
      .top_data  (stack_top),
      .count     (stack_count)
   );

   // Another division follows while the quotient is non-zero and digits remain.
   assign count_after = stack_count + 1'b1;
   assign more_digits = (div_quo != '0) && (count_after < MAX_DIGITS);

   assign req_xfer = req_chan.valid && req_chan.ready;
   assign rsp_xfer = rsp_chan.valid && rsp_chan.ready;

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_chan.valid) begin
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (base_bad || char_bad) begin
               state_in = ST_IDLE;
            end else if (scan_end) begin
               state_in = ST_DIV_LOAD;
            end
         end
         ST_DIV_LOAD: begin
            state_in = ST_DIV_WAIT;
         end
         ST_DIV_WAIT: begin
            if (div_done) begin
               if (more_digits) begin
                  state_in = ST_DIV_LOAD;
               end else if (neg_ff) begin
                  state_in = ST_SIGN;
               end else begin
                  state_in = ST_DIGITS;
               end
            end
         end
         ST_SIGN: begin
            if (rsp_chan.ready) begin
               state_in = ST_DIGITS;
            end
         end
         ST_DIGITS: begin
            if (rsp_chan.ready && (stack_count == ONE_LEFT)) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Outputs of the sequencer.
   always_comb begin
      req_chan.ready    = 1'b0;
      rsp_chan.valid    = 1'b0;
      rsp_chan.out_char = digit_char(digit_lo_ff, digit_hi_ff, ALPHA_IDX_BITS'(stack_top));
      rsp_chan.last     = 1'b0;
      div_start         = 1'b0;
      stack_ctrl        = '0;
      case (state_ff)
         ST_IDLE: begin
            req_chan.ready   = 1'b1;
            stack_ctrl.clear = req_chan.valid;
         end
         ST_DIV_LOAD: begin
            div_start = 1'b1;
         end
         ST_DIV_WAIT: begin
            stack_ctrl.push = div_done;
         end
         ST_SIGN: begin
            rsp_chan.valid    = 1'b1;
            rsp_chan.out_char = CH_MINUS;
         end
         ST_DIGITS: begin
            rsp_chan.valid = 1'b1;
            rsp_chan.last  = stack_count == ONE_LEFT;
            stack_ctrl.pop = rsp_xfer;
         end
         default: ;
      endcase
   end

   // Working registers: sign and magnitude on the transfer, quotient after each digit.
   always_comb begin
      neg_in      = neg_ff;
      mag_in      = mag_ff;
      scan_idx_in = scan_idx_ff;
      if (req_xfer) begin
         neg_in      = req_bits[VALUE_BITS-1];
         mag_in      = req_mag;
         scan_idx_in = '0;
      end else if (state_ff == ST_CHECK) begin
         scan_idx_in = scan_idx_ff + 1'b1;
      end else if ((state_ff == ST_DIV_WAIT) && div_done) begin
         mag_in = div_quo;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      neg_ff      <= neg_in;
      mag_ff      <= mag_in;
      scan_idx_ff <= scan_idx_in;
   end

endmodule

FILE: rtl/sre_divider.sv
// Restoring divider, one quotient bit per cycle, shared by every digit of a number.
`timescale 1ns / 1ps

module sre_divider import sre_pkg::*; #(
   parameter int VALUE_BITS = VALUE_BITS_DEFAULT,
   parameter int MAX_BASE   = MAX_BASE_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   input  logic [VALUE_BITS-1:0]                dividend,
   input  logic [BASE_BITS-1:0]                 divisor,
   output logic                                 done,
   output logic [VALUE_BITS-1:0]                quotient,
   output logic [$clog2(MAX_BASE)-1:0]          remainder
);

   localparam int DIGIT_BITS = $clog2(MAX_BASE);
   localparam int REM_BITS   = DIGIT_BITS + 1;
   localparam int CNT_BITS   = $clog2(VALUE_BITS);
   localparam logic [CNT_BITS-1:0] LAST_STEP = CNT_BITS'(VALUE_BITS - 1);

   logic [VALUE_BITS-1:0] quo_ff, quo_in;
   logic [REM_BITS-1:0]   rem_ff, rem_in;
   logic [CNT_BITS-1:0]   cnt_ff, cnt_in;
   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;

   logic [REM_BITS-1:0]  shifted;
   logic [BASE_BITS-1:0] trial;
   logic                 fits;

   // One restoring step: bring down the next dividend bit and try a subtraction.
   always_comb begin
      shifted = {rem_ff[REM_BITS-2:0], quo_ff[VALUE_BITS-1]};
      fits    = BASE_BITS'(shifted) >= divisor;
      trial   = BASE_BITS'(shifted) - divisor;
   end

   // Next values of the divider registers.
   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         quo_in  = dividend;
         rem_in  = '0;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         quo_in = {quo_ff[VALUE_BITS-2:0], fits};
         rem_in = fits ? REM_BITS'(trial) : shifted;
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == LAST_STEP) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // Control registers reset; the working values need none.
   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
   end

   assign done      = done_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff[DIGIT_BITS-1:0];

endmodule

FILE: rtl/sre_digit_stack.sv
// Last-in first-out store that turns the low-first digits into high-first order.
`timescale 1ns / 1ps

module sre_digit_stack import sre_pkg::*; #(
   parameter int DEPTH      = VALUE_BITS_DEFAULT,
   parameter int DATA_BITS  = $clog2(MAX_BASE_DEFAULT)
) (
   input  logic                       clock,
   input  logic                       reset,
   input  stack_ctrl_type             ctrl,
   input  logic [DATA_BITS-1:0]       push_data,
   output logic [DATA_BITS-1:0]       top_data,
   output logic [$clog2(DEPTH+1)-1:0] count
);

   localparam int CNT_BITS = $clog2(DEPTH + 1);
   localparam int IDX_BITS = $clog2(DEPTH);

   logic [DATA_BITS-1:0] entry_ff [DEPTH];
   logic [CNT_BITS-1:0]  count_ff, count_in;
   logic [CNT_BITS-1:0]  top_pos;

   // Fill level: a clear wins, then a push, then a pop.
   always_comb begin
      count_in = count_ff;
      if (ctrl.clear) begin
         count_in = '0;
      end else if (ctrl.push) begin
         count_in = count_ff + 1'b1;
      end else if (ctrl.pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   // A push writes at the current fill level.
   always_ff @(posedge clock) begin
      if (ctrl.push) begin
         entry_ff[count_ff[IDX_BITS-1:0]] <= push_data;
      end
   end

   assign top_pos  = count_ff - 1'b1;
   assign top_data = entry_ff[top_pos[IDX_BITS-1:0]];
   assign count    = count_ff;

endmodule

FILE: rtl/sre_alpha_scan.sv
// Checks one alphabet entry against the forbidden characters and all entries below it.
`timescale 1ns / 1ps

module sre_alpha_scan import sre_pkg::*; (
   input  logic [TABLE_BITS-1:0]     digit_lo,
   input  logic [TABLE_BITS-1:0]     digit_hi,
   input  logic [ALPHA_IDX_BITS-1:0] idx,
   output logic                      bad
);

   logic [CHAR_BITS-1:0] this_char;

   // Entry idx is bad if it is a sign, a zero byte, or equals an earlier entry.
   always_comb begin
      this_char = digit_char(digit_lo, digit_hi, idx);
      bad = (this_char == CH_NUL) || (this_char == CH_PLUS) || (this_char == CH_MINUS);
      for (int j = 0; j < ALPHA_DEPTH; j++) begin
         if ((ALPHA_IDX_BITS'(j) < idx) &&
             (digit_char(digit_lo, digit_hi, ALPHA_IDX_BITS'(j)) == this_char)) begin
            bad = 1'b1;
         end
      end
   end

endmodule
